### src/json_key_value_locator_defines.svh
// Assertion macros shared by the checker of the JSON key locator.
`ifndef JSON_KEY_VALUE_LOCATOR_DEFINES_SVH
`define JSON_KEY_VALUE_LOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JKVL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JKVL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/jkvl_pkg.sv
// Types, constants and helpers shared by the JSON key locator files.
package jkvl_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MID_HI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HI     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN    = 3'd4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [4:0] {
    PH_SEEK_QUOTE = 5'b00001,
    PH_MATCH      = 5'b00010,
    PH_SEEK_COLON = 5'b00100,
    PH_SKIP_WS    = 5'b01000,
    PH_IDLE       = 5'b10000
  } phase_t;

  // Whitespace: space, tab, LF, VT, FF and CR; JSON itself allows only space, tab, LF and CR.
  function automatic logic is_ws(logic [7:0] b);
    return b inside {CH_SPACE, [CH_TAB:CH_CR]};
  endfunction

endpackage

### src/json_key_value_locator.sv
// Each result is registered from the byte that produces it; an output stall holds it back.
// Throughput: one document byte per cycle while the pending register is empty; the byte
// compare, the phase update and the result register all settle with each accepted byte.
// A pending register holds a second result, so input stalls only while two results wait.
// Reset clears the key registers, the key length, the scan state and the byte count.
// Configuration writes are taken in every cycle.
module json_key_value_locator #(
  parameter int MAX_KEY_BYTES = 32,
  parameter int OFFSET_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] doc_byte
  input  logic                             s_tlast,   // end_of_doc
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [23:0]                      m_tdata,   // [15:0] value_offset, [23:16] value_first_byte
  output logic [0:0]                       m_tuser,   // [0] found
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [jkvl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                      cfg_data
);
  import jkvl_pkg::*;

  localparam int KI_W = $clog2(MAX_KEY_BYTES + 1);

  phase_t                 phase, phase_next;
  logic [KI_W-1:0]        key_index, key_index_next;
  logic                   last_quote, last_quote_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_inc;

  logic [KI_W-1:0]        key_len;
  logic [7:0]             key_byte;

  logic                   accept;
  logic [7:0]             doc_byte;
  logic                   hit;
  logic                   at_end;
  logic                   emit;
  logic                   res_found;
  logic [15:0]            res_offset;
  logic [7:0]             res_first;
  logic [OFFSET_BITS+15:0] pos_ext;
  logic [OFFSET_BITS+15:0] pos_inc_ext;

  logic                   pend_valid;
  logic [23:0]            pend_tdata;
  logic [0:0]             pend_tuser;

  assign cfg_ready = 1'b1;

  jkvl_key_store #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_key_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .rd_index (key_index),
    .rd_byte  (key_byte),
    .key_len  (key_len)
  );

  // A new request is taken as long as the pending result register is empty.
  assign s_tready = !pend_valid;
  assign accept   = s_tvalid && s_tready;
  assign doc_byte = s_tdata;

  assign byte_position_inc = byte_position + OFFSET_BITS'(1);
  assign pos_ext           = {16'b0, byte_position};
  assign pos_inc_ext       = {16'b0, byte_position_inc};

  always_comb begin
    phase_next      = phase;
    key_index_next  = key_index;
    last_quote_next = last_quote;
    hit             = 1'b0;
    case (phase)
      PH_SEEK_QUOTE: begin
        if (doc_byte == CH_QUOTE) begin
          phase_next      = PH_MATCH;
          key_index_next  = '0;
          last_quote_next = 1'b1;
        end
      end
      PH_MATCH: begin
        last_quote_next = (doc_byte == CH_QUOTE);
        if (key_index < key_len && doc_byte == key_byte) begin
          key_index_next = key_index + KI_W'(1);
        end else begin
          // The byte after a full match must close the key string.
          phase_next     = (key_index >= key_len && doc_byte == CH_QUOTE) ? PH_SEEK_COLON
                                                                          : PH_SEEK_QUOTE;
          key_index_next = '0;
        end
      end
      PH_SEEK_COLON: begin
        if (doc_byte == CH_COLON) begin
          phase_next = PH_SKIP_WS;
        end
      end
      PH_SKIP_WS: begin
        if (!is_ws(doc_byte)) begin
          hit        = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  // A document that ends once the key is closed reports the value at its end.
  assign at_end = (phase_next == PH_SEEK_COLON) || (phase_next == PH_SKIP_WS) ||
                  (phase_next == PH_MATCH && key_index_next >= key_len && last_quote_next);

  assign emit       = hit || s_tlast;
  assign res_found  = hit || (s_tlast && at_end);
  assign res_offset = hit ? pos_ext[15:0] : (res_found ? pos_inc_ext[15:0] : 16'h0000);
  assign res_first  = hit ? doc_byte : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SEEK_QUOTE;
      key_index     <= '0;
      last_quote    <= 1'b0;
      byte_position <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        phase         <= PH_SEEK_QUOTE;
        key_index     <= '0;
        last_quote    <= 1'b0;
        byte_position <= '0;
      end else begin
        phase         <= phase_next;
        key_index     <= key_index_next;
        last_quote    <= last_quote_next;
        byte_position <= byte_position_inc;
      end
    end
  end

  // The pending register is filled only while the output register is held,
  // and it drains into the output register first.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid   <= pend_valid || (accept && emit);
      pend_valid <= 1'b0;
    end else if (accept && emit) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (pend_valid) begin
        m_tdata <= pend_tdata;
        m_tuser <= pend_tuser;
      end else if (accept && emit) begin
        m_tdata <= {res_first, res_offset};
        m_tuser <= res_found;
      end
    end else if (accept && emit) begin
      pend_tdata <= {res_first, res_offset};
      pend_tuser <= res_found;
    end
  end

endmodule

### src/jkvl_key_store.sv
// Key byte store and key length register, written through the config port.
module jkvl_key_store #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [jkvl_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [63:0]                          wr_data,
  input  logic [$clog2(MAX_KEY_BYTES+1)-1:0]   rd_index,
  output logic [7:0]                           rd_byte,
  output logic [$clog2(MAX_KEY_BYTES+1)-1:0]   key_len
);
  import jkvl_pkg::*;

  localparam int KI_W  = $clog2(MAX_KEY_BYTES + 1);
  localparam int IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  logic [7:0] key_mem [MAX_KEY_BYTES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
        key_mem[i] <= 8'h00;
      end
      key_len <= '0;
    end else if (wr_en) begin
      // Each key register carries eight bytes, lowest byte first.
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
        if (wr_index == REG_KEY_LO + CFG_IDX_W'(i / 8)) begin
          key_mem[i] <= wr_data[(i % 8) * 8 +: 8];
        end
      end
      if (wr_index == REG_KEY_LEN) begin
        key_len <= (wr_data[5:0] > MAX_KEY_BYTES) ? KI_W'(MAX_KEY_BYTES)
                                                  : KI_W'(wr_data[5:0]);
      end
    end
  end

  assign rd_byte = key_mem[rd_index[IDX_W-1:0]];

endmodule

### src/jkvl_checker.sv
// Port-level checker for the JSON key locator, bound to the top level.
`include "json_key_value_locator_defines.svh"

module jkvl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [0:0]  m_tuser
);

  `JKVL_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `JKVL_ASSERT_NOW(a_not_found_zero, m_tvalid && !m_tuser[0], m_tdata == 24'h000000, "not-found result carries nonzero data")
  `JKVL_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with an empty output register")
  `JKVL_ASSERT_NEXT(a_no_spurious_result, (!m_tvalid || m_tready) && s_tready && !s_tvalid, !m_tvalid, "result appeared without an accepted request")

endmodule

bind json_key_value_locator jkvl_checker u_jkvl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
